FILE: sv/nqse_pkg.sv
package nqse_pkg;

   localparam int MAX_BOARD_DEF = 8;
   localparam int SIZE_W = 4;
   localparam int ROW_W = 4;
   localparam int ADDR_W = 4;
   localparam int PLACE_W = 32;
   localparam int COUNT_W = 32;
   localparam int NIBBLES = PLACE_W / 4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic operation;
      logic [SIZE_W-1:0] board_size;
   } req_item_type;

   typedef struct packed {
      logic found;
      logic exhausted;
      logic [PLACE_W-1:0] placement;
      logic [COUNT_W-1:0] solution_count;
   } rsp_item_type;

   typedef struct packed {
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ROW_W-1:0] wr_data;
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_TRY,
      ST_SCAN,
      ST_PACK_RD,
      ST_PACK_ACC
   } state_type;

endpackage

FILE: sv/nqse_row_mem.sv
module nqse_row_mem
   import nqse_pkg::*;
#(
   parameter int DEPTH = MAX_BOARD_DEF
) (
   input  logic clock,
   input  mem_cmd_type mem_cmd,
   output logic [ROW_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr[AW-1:0]] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[mem_cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/nqse_ctrl.sv
module nqse_ctrl
   import nqse_pkg::*;
#(
   parameter int MAX_BOARD = MAX_BOARD_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_item_type req_data,
   output logic rsp_strobe,
   output rsp_item_type rsp_data,
   output mem_cmd_type mem_cmd,
   input  logic [ROW_W-1:0] mem_rdata
);

   localparam int IW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
   localparam int CW = ROW_W + 1;
   localparam logic [SIZE_W-1:0] SizeMax = SIZE_W'(MAX_BOARD);

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic searching_ff, searching_in;
   logic [IW-1:0] col_ff, col_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] row_ff, row_in;
   logic [PLACE_W-1:0] place_ff, place_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [SIZE_W-1:0] new_size;
   logic [CW-1:0] other;
   logic [CW-1:0] row_dist;
   logic [CW-1:0] col_dist;
   logic conflict;
   logic cand_ok;
   logic last_col;
   logic do_place;
   logic [COUNT_W-1:0] count_next;
   logic [PLACE_W-1:0] nibble;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= '0;
         searching_ff <= 1'b0;
         total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         searching_ff <= searching_in;
         total_ff <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      idx_ff <= idx_in;
      row_ff <= row_in;
      place_ff <= place_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      new_size = (req_data.board_size > SizeMax) ? SizeMax : req_data.board_size;
      other = {1'b0, mem_rdata};
      row_dist = (other > row_ff) ? (other - row_ff) : (row_ff - other);
      col_dist = CW'(col_ff - idx_ff);
      conflict = (other == row_ff) || (row_dist == col_dist);
      cand_ok = (row_ff <= {1'b0, size_ff});
      last_col = (SIZE_W'(col_ff) == (size_ff - SIZE_W'(1)));
      count_next = (total_ff == '1) ? total_ff : (total_ff + COUNT_W'(1));
      nibble = PLACE_W'(mem_rdata - ROW_W'(1)) << {idx_ff, 2'b00};

      state_in = state_ff;
      size_in = size_ff;
      searching_in = searching_ff;
      col_in = col_ff;
      idx_in = idx_ff;
      row_in = row_ff;
      place_in = place_ff;
      total_in = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      mem_cmd = '0;
      do_place = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.operation == OP_START) begin
                  size_in = new_size;
                  searching_in = (new_size != '0);
                  col_in = '0;
                  mem_cmd.wr_en = 1'b1;
                  mem_cmd.wr_addr = '0;
                  mem_cmd.wr_data = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{found: 1'b0, exhausted: (new_size == '0),
                             placement: '0, solution_count: total_ff};
               end else if (!searching_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{found: 1'b0, exhausted: 1'b1,
                             placement: '0, solution_count: total_ff};
               end else begin
                  // resume at the column of the last placement
                  mem_cmd.rd_en = 1'b1;
                  mem_cmd.rd_addr = ADDR_W'(col_ff);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            row_in = other + CW'(1);
            state_in = ST_TRY;
         end
         ST_TRY: begin
            if (!cand_ok) begin
               if (col_ff == '0) begin
                  searching_in = 1'b0;
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{found: 1'b0, exhausted: 1'b1,
                             placement: '0, solution_count: total_ff};
                  state_in = ST_IDLE;
               end else begin
                  // backtrack: fetch the previous column's row
                  col_in = col_ff - IW'(1);
                  mem_cmd.rd_en = 1'b1;
                  mem_cmd.rd_addr = ADDR_W'(col_ff - IW'(1));
                  state_in = ST_LOAD;
               end
            end else if (col_ff == '0) begin
               do_place = 1'b1;
            end else begin
               idx_in = '0;
               mem_cmd.rd_en = 1'b1;
               mem_cmd.rd_addr = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (conflict) begin
               row_in = row_ff + CW'(1);
               state_in = ST_TRY;
            end else if ((idx_ff + IW'(1)) == col_ff) begin
               do_place = 1'b1;
            end else begin
               idx_in = idx_ff + IW'(1);
               mem_cmd.rd_en = 1'b1;
               mem_cmd.rd_addr = ADDR_W'(idx_ff + IW'(1));
            end
         end
         ST_PACK_RD: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.rd_addr = ADDR_W'(idx_ff);
            state_in = ST_PACK_ACC;
         end
         ST_PACK_ACC: begin
            // drop columns beyond what the placement word holds
            if (SIZE_W'(idx_ff) < SIZE_W'(NIBBLES)) begin
               place_in = place_ff | nibble;
            end
            if (SIZE_W'(idx_ff) == (size_ff - SIZE_W'(1))) begin
               total_in = count_next;
               rsp_strobe_in = 1'b1;
               rsp_in = '{found: 1'b1, exhausted: 1'b0,
                          placement: place_in, solution_count: count_next};
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = ST_PACK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_place) begin
         mem_cmd.wr_en = 1'b1;
         mem_cmd.wr_addr = ADDR_W'(col_ff);
         mem_cmd.wr_data = row_ff[ROW_W-1:0];
         if (last_col) begin
            place_in = '0;
            idx_in = '0;
            state_in = ST_PACK_RD;
         end else begin
            col_in = col_ff + IW'(1);
            row_in = CW'(1);
            state_in = ST_TRY;
         end
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: sv/n_queens_solution_enumerator.sv
// Start, and next while no search is open: result in the cycle after acceptance, busy stays low.
// Next during a search: a fetch per column, a try per candidate row plus a compare per
// earlier column checked against it, then a read and an accumulate step per column to pack.
// The column row memory has a single read port, so each stored row is read on its own.
// One item at a time; the receiver cannot stall.
// Synchronous reset clears the search, the solution count and the result strobe.
module n_queens_solution_enumerator
   import nqse_pkg::*;
#(
   parameter int MAX_BOARD = MAX_BOARD_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_item_type req_data,
   output logic rsp_strobe,
   output rsp_item_type rsp_data
);

   mem_cmd_type mem_cmd;
   logic [ROW_W-1:0] mem_rdata;

   nqse_ctrl #(
      .MAX_BOARD(MAX_BOARD)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .mem_cmd(mem_cmd),
      .mem_rdata(mem_rdata)
   );

   nqse_row_mem #(
      .DEPTH(MAX_BOARD)
   ) u_row_mem (
      .clock(clock),
      .mem_cmd(mem_cmd),
      .rd_data(mem_rdata)
   );

endmodule

FILE: sv/nqse_checker.sv
module nqse_checker
   import nqse_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input req_item_type req_data,
   input logic rsp_strobe,
   input rsp_item_type rsp_data
);

   logic start_acc;
   logic next_acc;

   assign start_acc = start && !busy && (req_data.operation == OP_START);
   assign next_acc = start && !busy && (req_data.operation == OP_NEXT);

   // a word leaves only once the search has parked
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word while busy");

   assert property (@(posedge clock) disable iff (reset)
      start_acc |=> rsp_strobe && !rsp_data.found && (rsp_data.placement == '0))
      else $error("start did not answer with an empty word");

   assert property (@(posedge clock) disable iff (reset)
      (start_acc && (req_data.board_size == '0)) |=> rsp_data.exhausted)
      else $error("empty board not reported as exhausted");

   assert property (@(posedge clock) disable iff (reset)
      next_acc |=> (rsp_strobe || busy))
      else $error("next neither answered nor searching");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |-> (rsp_data.solution_count != '0))
      else $error("solution reported with zero count");

endmodule

bind n_queens_solution_enumerator nqse_checker u_nqse_checker (.*);
